FILE: rtl/max_priority_queue_stable_defines.svh
// Assertion helpers used by the queue RTL.
`ifndef MAX_PRIORITY_QUEUE_STABLE_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_STABLE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define MPQS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define MPQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mpqs_pkg.sv
`timescale 1ns / 1ps

package mpqs_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 8;
    localparam int ENTRY_W      = 2 * DATA_W;

    // mode codes on the input tuser
    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    // status codes on the output tuser
    typedef enum logic [1:0] {
        ST_ENQUEUED  = 2'd0,
        ST_DEQUEUED  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

endpackage

FILE: rtl/max_priority_queue_stable.sv
`timescale 1ns / 1ps

// Bounded max-priority queue, CAPACITY entries of (value, priority), kept in
// arrival order in one simple dual-port memory. Each input transfer carries a
// mode on tuser (0 enqueue, 1 dequeue) and the pair on tdata; each produces
// exactly one output transfer with the status on tuser and the removed pair
// plus the resulting occupancy on tdata. An enqueue writes the pair behind the
// last entry; its result goes through S_DONE into the output register, and the
// next item can be accepted once the sequencer is back in S_IDLE (overflow and
// underflow likewise). A dequeue runs the single priority comparator over the
// held entries at one entry per cycle, picking the oldest entry among those of
// highest signed priority, and then closes the gap by moving each later entry
// down one slot, again one per cycle through the memory port pair; the result
// then waits in S_DONE until the output register is free.
// s_axis_tready is high only while the sequencer is idle; the output register
// lets the next item be accepted while the previous result still waits for
// m_axis_tready.
module max_priority_queue_stable
    import mpqs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ENTRY_W-1:0]   s_axis_tdata,   // [31:0] item_value, [63:32] item_priority
    input  logic                 s_axis_tuser,   // [0] mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ENTRY_W+OCC_W-1:0] m_axis_tdata, // [31:0] out_value, [63:32] out_priority,
                                                   // [71:64] occupancy
    output logic [1:0]           m_axis_tuser    // [1:0] status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;     // next address to read
    logic                   rd_valid_reg, rd_valid_next; // read data is back this cycle
    logic [CW-1:0]          cmp_idx_reg, cmp_idx_next;   // index of the data now back
    logic [CW-1:0]          best_idx_reg, best_idx_next;
    logic [ENTRY_W-1:0]     best_reg, best_next;         // winning pair so far
    status_t                res_status_reg, res_status_next;
    logic [ENTRY_W-1:0]     res_pair_reg, res_pair_next;
    logic                   m_valid_reg, m_valid_next;
    logic [ENTRY_W+OCC_W-1:0] m_data_reg, m_data_next;
    logic [1:0]             m_user_reg, m_user_next;

    // entry memory: value in the low half, priority in the high half
    logic [ENTRY_W-1:0]     mem [CAPACITY];
    logic [ENTRY_W-1:0]     mem_rdata_reg;
    logic                   mem_we, mem_re;
    logic [IW-1:0]          mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]     mem_wdata;

    logic                   s_accept;
    logic                   issue;
    logic                   take;
    logic                   last_cmp;
    logic                   out_free;
    logic                   enq_fits;
    logic [CW-1:0]          write_pos;
    logic signed [DATA_W-1:0] rd_pri, best_pri;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // shared comparator: oldest entry wins ties, so only a strict win replaces
    assign rd_pri   = mem_rdata_reg[ENTRY_W-1:DATA_W];
    assign best_pri = best_reg[ENTRY_W-1:DATA_W];
    assign take     = (cmp_idx_reg == '0) || (rd_pri > best_pri);
    assign last_cmp = (cmp_idx_reg == count_reg - ONE_C);
    assign issue    = (rd_idx_reg < count_reg);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign write_pos = cmp_idx_reg - ONE_C;
    assign enq_fits = s_accept && (s_axis_tuser == MODE_ENQUEUE) && (count_reg < CAP_C);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_valid_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_pair_next   = res_pair_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IW-1:0];
        mem_wdata       = s_axis_tdata;
        mem_re          = 1'b0;
        mem_raddr       = rd_idx_reg[IW-1:0];

        // drop the output once the downstream side takes it
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_pair_next = '0;
                    state_next    = S_DONE;
                    if (s_axis_tuser == MODE_ENQUEUE) begin
                        if (count_reg < CAP_C) begin
                            mem_we          = 1'b1;
                            count_next      = count_reg + ONE_C;
                            res_status_next = ST_ENQUEUED;
                        end else begin
                            res_status_next = ST_OVERFLOW;
                        end
                    end else if (count_reg == '0) begin
                        res_status_next = ST_UNDERFLOW;
                    end else begin
                        rd_idx_next = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // stream reads, compare the entry that came back
                if (issue) begin
                    mem_re        = 1'b1;
                    rd_idx_next   = rd_idx_reg + ONE_C;
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = rd_idx_reg;
                end
                if (rd_valid_reg) begin
                    if (take) begin
                        best_idx_next = cmp_idx_reg;
                        best_next     = mem_rdata_reg;
                    end
                    if (last_cmp) begin
                        rd_idx_next = (take ? cmp_idx_reg : best_idx_reg) + ONE_C;
                        state_next  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // move every entry behind the winner down one slot
                if (issue) begin
                    mem_re        = 1'b1;
                    rd_idx_next   = rd_idx_reg + ONE_C;
                    rd_valid_next = 1'b1;
                    cmp_idx_next  = rd_idx_reg;
                end
                if (rd_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = write_pos[IW-1:0];
                    mem_wdata = mem_rdata_reg;
                end
                if (!issue && !rd_valid_reg) begin
                    count_next      = count_reg - ONE_C;
                    res_status_next = ST_DEQUEUED;
                    res_pair_next   = best_reg;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {OCC_W'(count_reg), res_pair_reg};
                    m_user_next  = res_status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_pair_reg   <= res_pair_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

`include "max_priority_queue_stable_defines.svh"

    `MPQS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_C, "entry count above capacity")
    `MPQS_ASSERT_NOW(a_cmp_in_range, rd_valid_reg, cmp_idx_reg < count_reg, "read past count")
    `MPQS_ASSERT_NEXT(a_enq_count, enq_fits, count_reg == $past(count_reg) + ONE_C, "count stuck")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import mpqs_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int QUEUE_DEPTH  = CAPACITY_DEF;
    // longest dequeue scans and shifts the whole depth; allow a wide margin
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 300;

    // one result transfer, unpacked from m_axis_tuser / m_axis_tdata
    typedef struct {
        status_t            status;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  prio;
        logic [OCC_W-1:0]   occupancy;
    } queue_result_t;

    // one held entry, kept in arrival order
    typedef struct {
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  prio;
    } queue_entry_t;

    // directed stimulus row; typed rows carry their own expected result
    typedef struct {
        logic               mode;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  prio;
        bit                 typed;
        queue_result_t      result;
    } stim_row_t;

    localparam queue_result_t FROM_MODEL = '{ST_ENQUEUED, 32'h0, 32'h0, 8'd0};

    logic                        aclk;
    logic                        aresetn;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [ENTRY_W-1:0]          s_axis_tdata;   // [31:0] item_value, [63:32] item_priority
    logic                        s_axis_tuser;   // [0] mode
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [ENTRY_W+OCC_W-1:0]    m_axis_tdata;   // [31:0] out_value, [63:32] out_priority,
                                                 // [71:64] occupancy
    logic [1:0]                  m_axis_tuser;   // [1:0] status

    queue_entry_t   held_entries[$];     // predicted queue contents
    queue_result_t  pending_results[$];  // results still owed by the block
    int             err_count;
    int             src_idle_pct;
    int             snk_idle_pct;
    int             quiet_cycles;

    // random walk of the fill level: climb toward hi_mark, then fall toward lo_mark
    bit             filling;
    int             hi_mark;
    int             lo_mark;

    // Directed rows: extremes first, signed ordering and ties, then a short
    // tie-breaking sequence checked against the predictor.
    stim_row_t dir_rows [0:24] = '{
        // dequeue right after reset: underflow
        '{MODE_DEQUEUE, 32'h1234_5678, 32'h8765_4321, 1'b1,
          '{ST_UNDERFLOW, 32'h0, 32'h0, 8'd0}},
        '{MODE_ENQUEUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          '{ST_ENQUEUED, 32'h0, 32'h0, 8'd1}},
        '{MODE_ENQUEUE, 32'h8000_0000, 32'h8000_0000, 1'b1,
          '{ST_ENQUEUED, 32'h0, 32'h0, 8'd2}},
        '{MODE_ENQUEUE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          '{ST_ENQUEUED, 32'h0, 32'h0, 8'd3}},
        '{MODE_ENQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_ENQUEUED, 32'h0, 32'h0, 8'd4}},
        '{MODE_ENQUEUE, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1,
          '{ST_ENQUEUED, 32'h0, 32'h0, 8'd5}},
        // tie at the top priority: oldest leaves first
        '{MODE_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ST_DEQUEUED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd4}},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_DEQUEUED, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'd3}},
        // signed order: 0 beats -1 beats the most negative
        '{MODE_DEQUEUE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
          '{ST_DEQUEUED, 32'h0000_0000, 32'h0000_0000, 8'd2}},
        '{MODE_DEQUEUE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
          '{ST_DEQUEUED, 32'h0000_0005, 32'hFFFF_FFFF, 8'd1}},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_DEQUEUED, 32'h8000_0000, 32'h8000_0000, 8'd0}},
        '{MODE_DEQUEUE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_UNDERFLOW, 32'h0, 32'h0, 8'd0}},
        // equal priorities interleaved with a higher one and a late arrival
        '{MODE_ENQUEUE, 32'd1, 32'd10, 1'b0, FROM_MODEL},
        '{MODE_ENQUEUE, 32'd2, 32'd10, 1'b0, FROM_MODEL},
        '{MODE_ENQUEUE, 32'd3, 32'd10, 1'b0, FROM_MODEL},
        '{MODE_ENQUEUE, 32'd4, 32'd20, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL},
        '{MODE_ENQUEUE, 32'd5, 32'd10, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL},
        '{MODE_ENQUEUE, 32'd6, 32'hFFFF_FFF6, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL},
        '{MODE_DEQUEUE, 32'd0, 32'd0, 1'b0, FROM_MODEL}
    };

    max_priority_queue_stable #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // Apply one queue operation to the predicted contents and return the result.
    // Dequeue picks the highest signed priority; the first hit in arrival order
    // wins a tie, and the later entries close up behind it.
    function automatic queue_result_t apply_queue_op(logic mode, logic [DATA_W-1:0] value,
                                                     logic [DATA_W-1:0] prio);
        queue_result_t r;
        int            best;
        r = '{ST_ENQUEUED, '0, '0, '0};
        if (mode == MODE_ENQUEUE) begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                held_entries.push_back('{value, prio});
            end
        end else if (held_entries.size() == 0) begin
            r.status = ST_UNDERFLOW;
        end else begin
            best = 0;
            for (int i = 1; i < held_entries.size(); i++) begin
                if ($signed(held_entries[i].prio) > $signed(held_entries[best].prio)) begin
                    best = i;
                end
            end
            r.status = ST_DEQUEUED;
            r.value  = held_entries[best].value;
            r.prio   = held_entries[best].prio;
            held_entries.delete(best);
        end
        r.occupancy = OCC_W'(held_entries.size());
        return r;
    endfunction

    // Present one item at the falling edge, hold it until the rising edge that
    // completes the transfer, then log what the block owes for it.
    task automatic send_item(logic mode, logic [DATA_W-1:0] value, logic [DATA_W-1:0] prio,
                             bit typed, queue_result_t typed_result);
        queue_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {prio, value};
        s_axis_tuser  = mode;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = apply_queue_op(mode, value, prio);
        pending_results.push_back(typed ? typed_result : predicted);
        @(negedge aclk);
    endtask

    // Hold off the sender until the block has delivered every owed result.
    task automatic wait_all_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Priorities lean on extremes and a narrow band so that ties are common.
    function automatic logic [DATA_W-1:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return DATA_W'($signed($urandom_range(0, 8)) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return DATA_W'($urandom_range(0, 63)) << $urandom_range(0, 26);
        endcase
    endfunction

    // Random items: drift the fill level up to a mark and down again, mostly
    // toward full or empty so that overflow and underflow both occur.
    task automatic send_random(int count);
        logic mode;
        int   level;
        for (int n = 0; n < count; n++) begin
            level = held_entries.size();
            if (filling && level >= hi_mark && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
                lo_mark = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 40);
            end else if (!filling && level <= lo_mark && $urandom_range(0, 3) == 0) begin
                filling = 1'b1;
                hi_mark = ($urandom_range(0, 1) == 0) ? QUEUE_DEPTH
                                                     : $urandom_range(8, QUEUE_DEPTH);
            end
            if ($urandom_range(0, 99) < 80) begin
                mode = filling ? MODE_ENQUEUE : MODE_DEQUEUE;
            end else begin
                mode = filling ? MODE_DEQUEUE : MODE_ENQUEUE;
            end
            send_item(mode, $urandom(), pick_prio(), 1'b0, FROM_MODEL);
            if ($urandom_range(0, 149) == 0) wait_all_results();
        end
    endtask

    // Result side: stall at random, and compare every transfer with the oldest
    // owed result.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready = aresetn && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing owed: status %0d tdata %h",
                       m_axis_tuser, m_axis_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[31:0] !== want.value) begin
                    $error("out_value: expected %h, got %h", want.value, m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tdata[63:32] !== want.prio) begin
                    $error("out_priority: expected %h, got %h", want.prio,
                           m_axis_tdata[63:32]);
                    err_count++;
                end
                if (m_axis_tdata[71:64] !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           m_axis_tdata[71:64]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: give up when neither channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_ENQUEUE;
        err_count     = 0;
        filling       = 1'b1;
        hi_mark       = QUEUE_DEPTH;
        lo_mark       = 0;
        src_idle_pct  = 18;
        snk_idle_pct  = 78;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // phase one: sender mostly busy, receiver mostly stalled
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].prio,
                      dir_rows[i].typed, dir_rows[i].result);
        end
        send_random(300);
        wait_all_results();

        // phase two: sender mostly idle, receiver mostly ready
        src_idle_pct = 78;
        snk_idle_pct = 18;
        send_random(310);
        wait_all_results();

        // phase three: back-to-back on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(315);
        wait_all_results();

        // idle on both channels and catch any stray result
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
